### rtl/ats_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ats_pkg
// Shared types and constants for the alias-method sampler: field widths,
// fixed-point constants, request and status codes and the sequencer states.
// ============================================================================
package ats_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    // Fixed-point format of the weights.
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = 16;
    localparam int PROB_W    = 17;
    localparam int WEIGHT_W  = 25;
    localparam int SUM_W     = WEIGHT_W + 1;
    localparam int PROD_W    = WEIGHT_W + CNT_W;
    localparam int TSIZE_W   = 9;

    localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = WEIGHT_W'(64'd1 << FRAC_BITS);
    localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = {WEIGHT_W{1'b1}};
    localparam logic [TSIZE_W-1:0]  TSIZE_RESET = TSIZE_W'(256);

    // Stream payload widths.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    // Request kinds carried on the input tuser.
    typedef enum logic [S_TUSER_W-1:0] {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [M_TUSER_W-1:0] {
        STAT_LOAD_DONE    = 2'd0,
        STAT_SAMPLE_OK    = 2'd1,
        STAT_NOT_BUILT    = 2'd2,
        STAT_OUT_OF_RANGE = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_RESP,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_WR,
        ST_PR_POP,
        ST_PR_RDS,
        ST_PR_RDL,
        ST_PR_UPD,
        ST_DR_WR
    } state_t;

endpackage

### rtl/ats_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ats_ram
// Generic simple dual-port RAM: one write port and one read port with
// registered read data that holds while the read enable is low.
// ============================================================================
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/alias_table_sampler.sv
`timescale 1ns / 1ps
// ============================================================================
// alias_table_sampler
// Vose alias-method sampler with Q1.16 weights, built and read through one
// sequencer over block RAMs for weights, aliases and the two work stacks.
// ============================================================================
// A load request and a sample request each make a single access to the
// weight memory. A load with tlast set starts the table build, which runs
// from the one read port of the weight memory: a read, a multiply and a
// write per entry to scale the k weights, a pop, two reads and an update
// per small/large pairing, a pop and a write per leftover entry, and a
// final pop to finish. Pairings and leftovers together number k, and the
// response comes last. The block takes no new request until the result
// of the current one sits in the output register; a held result does not
// block the next request from being accepted. table_size may be written only
// while no request is in flight.
module alias_table_sampler (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: table_size.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ats_pkg::TSIZE_W-1:0]      cfg_data,
    // Request stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index[7:0], prob_value[24:8], rand_index[32:25],
    // random_fraction[48:33], zero fill [55:49]
    input  logic [ats_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type[0]
    input  logic [ats_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             s_tlast,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // picked_index[7:0]
    output logic [ats_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [ats_pkg::M_TUSER_W-1:0]    m_tuser
);

    import ats_pkg::*;

    // Control registers.
    state_t              state_reg, state_next;
    logic [TSIZE_W-1:0]  table_size_reg, table_size_next;
    logic                table_ready_reg, table_ready_next;
    logic [CNT_W-1:0]    small_cnt_reg, small_cnt_next;
    logic [CNT_W-1:0]    large_cnt_reg, large_cnt_next;
    logic                m_valid_reg, m_valid_next;

    // Payload registers.
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    ridx_reg, ridx_next;
    logic [FRAC_W-1:0]   rfrac_reg, rfrac_next;
    status_t             status_reg, status_next;
    logic [IDX_W-1:0]    s_idx_reg, s_idx_next;
    logic [IDX_W-1:0]    l_idx_reg, l_idx_next;
    logic [WEIGHT_W-1:0] ws_reg, ws_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                drain_small_reg, drain_small_next;
    logic [IDX_W-1:0]    m_pick_reg, m_pick_next;
    status_t             m_status_reg, m_status_next;

    // Memory ports.
    logic                w_we, w_re, a_we, a_re, ss_we, ss_re, ls_we, ls_re;
    logic [IDX_W-1:0]    w_waddr, w_raddr, a_waddr, a_raddr;
    logic [IDX_W-1:0]    ss_waddr, ss_raddr, ls_waddr, ls_raddr;
    logic [WEIGHT_W-1:0] w_wdata, w_rdata;
    logic [IDX_W-1:0]    a_wdata, a_rdata, ss_wdata, ss_rdata, ls_wdata, ls_rdata;

    // Request fields and helpers.
    logic                in_fire, cfg_fire, out_free;
    logic [IDX_W-1:0]    in_entry, in_ridx;
    logic [PROB_W-1:0]   in_prob;
    logic [FRAC_W-1:0]   in_rfrac;
    logic [CNT_W-1:0]    k_eff;
    logic [CNT_W-1:0]    small_top, large_top;
    logic [SUM_W-1:0]    pair_sum;
    logic [WEIGHT_W-1:0] reduced_w, scaled_w;
    logic [IDX_W-1:0]    drain_idx;
    logic                last_scale;

    assign in_entry = s_tdata[7:0];
    assign in_prob  = s_tdata[24:8];
    assign in_ridx  = s_tdata[32:25];
    assign in_rfrac = s_tdata[48:33];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pick_reg;
    assign m_tuser  = m_status_reg;

    // Effective table size: zero means one, anything above the store is clamped.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (CNT_W'(table_size_reg) > CNT_W'(MAX_ENTRIES))
        begin
            k_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            k_eff = CNT_W'(table_size_reg);
        end
    end

    // Shared arithmetic: stack tops, pairing reduction and scale saturation.
    assign small_top  = small_cnt_reg - CNT_W'(1);
    assign large_top  = large_cnt_reg - CNT_W'(1);
    assign pair_sum   = {1'b0, ws_reg} + {1'b0, w_rdata};
    assign reduced_w  = (pair_sum > {1'b0, ONE_WEIGHT}) ?
                        WEIGHT_W'(pair_sum - {1'b0, ONE_WEIGHT}) : '0;
    assign scaled_w   = (prod_reg > PROD_W'(MAX_WEIGHT)) ? MAX_WEIGHT :
                        prod_reg[WEIGHT_W-1:0];
    assign drain_idx  = drain_small_reg ? ss_rdata : ls_rdata;
    assign last_scale = ((idx_reg + CNT_W'(1)) == k_eff);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == REQ_LOAD)
                    begin
                        state_next = s_tlast ? ST_SC_RD : ST_RESP;
                    end
                    else if (!table_ready_reg || ({1'b0, in_ridx} >= k_eff))
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SAMPLE;
                    end
                end
            end
            ST_SAMPLE, ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SC_RD:  state_next = ST_SC_MUL;
            ST_SC_MUL: state_next = ST_SC_WR;
            ST_SC_WR:  state_next = last_scale ? ST_PR_POP : ST_SC_RD;
            ST_PR_POP:
            begin
                if ((small_cnt_reg != '0) && (large_cnt_reg != '0))
                begin
                    state_next = ST_PR_RDS;
                end
                else if ((small_cnt_reg != '0) || (large_cnt_reg != '0))
                begin
                    state_next = ST_DR_WR;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_PR_RDS: state_next = ST_PR_RDL;
            ST_PR_RDL: state_next = ST_PR_UPD;
            ST_PR_UPD: state_next = ST_PR_POP;
            ST_DR_WR:  state_next = ST_PR_POP;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control per state.
    always_comb
    begin
        table_size_next  = table_size_reg;
        table_ready_next = table_ready_reg;
        small_cnt_next   = small_cnt_reg;
        large_cnt_next   = large_cnt_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        idx_next         = idx_reg;
        ridx_next        = ridx_reg;
        rfrac_next       = rfrac_reg;
        status_next      = status_reg;
        s_idx_next       = s_idx_reg;
        l_idx_next       = l_idx_reg;
        ws_next          = ws_reg;
        prod_next        = prod_reg;
        drain_small_next = drain_small_reg;
        m_pick_next      = m_pick_reg;
        m_status_next    = m_status_reg;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_re = 1'b0; w_raddr = '0;
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
        ss_we = 1'b0; ss_waddr = '0; ss_wdata = '0; ss_re = 1'b0; ss_raddr = '0;
        ls_we = 1'b0; ls_waddr = '0; ls_wdata = '0; ls_re = 1'b0; ls_raddr = '0;

        if (cfg_fire)
        begin
            table_size_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ridx_next  = in_ridx;
                    rfrac_next = in_rfrac;
                    if (s_tuser == REQ_LOAD)
                    begin
                        table_ready_next = 1'b0;
                        if ({1'b0, in_entry} < k_eff)
                        begin
                            w_we        = 1'b1;
                            w_waddr     = in_entry;
                            w_wdata     = WEIGHT_W'(in_prob);
                            status_next = STAT_LOAD_DONE;
                        end
                        else
                        begin
                            status_next = STAT_OUT_OF_RANGE;
                        end
                        small_cnt_next = '0;
                        large_cnt_next = '0;
                        idx_next       = '0;
                    end
                    else
                    begin
                        w_re    = 1'b1;
                        w_raddr = in_ridx;
                        a_re    = 1'b1;
                        a_raddr = in_ridx;
                        if (!table_ready_reg)
                        begin
                            status_next = STAT_NOT_BUILT;
                        end
                        else
                        begin
                            status_next = STAT_OUT_OF_RANGE;
                        end
                    end
                end
            end
            ST_SAMPLE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_SAMPLE_OK;
                    m_pick_next   = ({{(WEIGHT_W-FRAC_W){1'b0}}, rfrac_reg} < w_rdata) ?
                                    ridx_reg : a_rdata;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pick_next   = '0;
                end
            end
            // Scale pass: w = min(k * w, max), then sort onto a stack.
            ST_SC_RD:
            begin
                w_re    = 1'b1;
                w_raddr = idx_reg[IDX_W-1:0];
            end
            ST_SC_MUL:
            begin
                prod_next = PROD_W'(k_eff) * PROD_W'(w_rdata);
            end
            ST_SC_WR:
            begin
                w_we     = 1'b1;
                w_waddr  = idx_reg[IDX_W-1:0];
                w_wdata  = scaled_w;
                idx_next = idx_reg + CNT_W'(1);
                if (scaled_w < ONE_WEIGHT)
                begin
                    ss_we          = 1'b1;
                    ss_waddr       = small_cnt_reg[IDX_W-1:0];
                    ss_wdata       = idx_reg[IDX_W-1:0];
                    small_cnt_next = small_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ls_we          = 1'b1;
                    ls_waddr       = large_cnt_reg[IDX_W-1:0];
                    ls_wdata       = idx_reg[IDX_W-1:0];
                    large_cnt_next = large_cnt_reg + CNT_W'(1);
                end
            end
            // Pop a pair, or a single leftover entry, or finish the build.
            ST_PR_POP:
            begin
                if ((small_cnt_reg != '0) && (large_cnt_reg != '0))
                begin
                    ss_re          = 1'b1;
                    ss_raddr       = small_top[IDX_W-1:0];
                    ls_re          = 1'b1;
                    ls_raddr       = large_top[IDX_W-1:0];
                    small_cnt_next = small_top;
                    large_cnt_next = large_top;
                end
                else if (small_cnt_reg != '0)
                begin
                    ss_re            = 1'b1;
                    ss_raddr         = small_top[IDX_W-1:0];
                    small_cnt_next   = small_top;
                    drain_small_next = 1'b1;
                end
                else if (large_cnt_reg != '0)
                begin
                    ls_re            = 1'b1;
                    ls_raddr         = large_top[IDX_W-1:0];
                    large_cnt_next   = large_top;
                    drain_small_next = 1'b0;
                end
                else
                begin
                    table_ready_next = 1'b1;
                end
            end
            ST_PR_RDS:
            begin
                s_idx_next = ss_rdata;
                l_idx_next = ls_rdata;
                w_re       = 1'b1;
                w_raddr    = ss_rdata;
            end
            ST_PR_RDL:
            begin
                ws_next = w_rdata;
                w_re    = 1'b1;
                w_raddr = l_idx_reg;
            end
            // Small entry aliases the large one; large weight loses the gap.
            ST_PR_UPD:
            begin
                w_we    = 1'b1;
                w_waddr = l_idx_reg;
                w_wdata = reduced_w;
                a_we    = 1'b1;
                a_waddr = s_idx_reg;
                a_wdata = l_idx_reg;
                if (reduced_w < ONE_WEIGHT)
                begin
                    ss_we          = 1'b1;
                    ss_waddr       = small_cnt_reg[IDX_W-1:0];
                    ss_wdata       = l_idx_reg;
                    small_cnt_next = small_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ls_we          = 1'b1;
                    ls_waddr       = large_cnt_reg[IDX_W-1:0];
                    ls_wdata       = l_idx_reg;
                    large_cnt_next = large_cnt_reg + CNT_W'(1);
                end
            end
            // Leftover entries keep full weight and alias themselves.
            ST_DR_WR:
            begin
                w_we    = 1'b1;
                w_waddr = drain_idx;
                w_wdata = ONE_WEIGHT;
                a_we    = 1'b1;
                a_waddr = drain_idx;
                a_wdata = drain_idx;
            end
            default:
            begin
                table_ready_next = table_ready_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_size_reg  <= TSIZE_RESET;
            table_ready_reg <= 1'b0;
            small_cnt_reg   <= '0;
            large_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            table_size_reg  <= table_size_next;
            table_ready_reg <= table_ready_next;
            small_cnt_reg   <= small_cnt_next;
            large_cnt_reg   <= large_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        ridx_reg        <= ridx_next;
        rfrac_reg       <= rfrac_next;
        status_reg      <= status_next;
        s_idx_reg       <= s_idx_next;
        l_idx_reg       <= l_idx_next;
        ws_reg          <= ws_next;
        prod_reg        <= prod_next;
        drain_small_reg <= drain_small_next;
        m_pick_reg      <= m_pick_next;
        m_status_reg    <= m_status_next;
    end

    // Weight, alias and the two work stacks.
    ats_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_ENTRIES)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_alias_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small_ram (
        .clk   (clk),
        .we    (ss_we),
        .waddr (ss_waddr),
        .wdata (ss_wdata),
        .re    (ss_re),
        .raddr (ss_raddr),
        .rdata (ss_rdata)
    );

    ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large_ram (
        .clk   (clk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (ls_wdata),
        .re    (ls_re),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    // The two stacks together never hold more entries than the table.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(small_cnt_reg) + (CNT_W + 1)'(large_cnt_reg)
            <= (CNT_W + 1)'(MAX_ENTRIES))
        else $error("work stacks exceed the table depth");

    // The table only becomes ready at the end of a build.
    a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(table_ready_reg) |-> (state_reg == ST_RESP) && ($past(state_reg) == ST_PR_POP))
        else $error("table marked ready outside a build");

    // A final load always starts the scale pass.
    a_build_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == REQ_LOAD) && s_tlast) |=> (state_reg == ST_SC_RD))
        else $error("final load did not start the build");

    // Each pairing step pushes the large entry onto exactly one stack.
    a_pair_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PR_UPD) |-> $onehot({ss_we, ls_we}))
        else $error("pairing step pushed to none or both stacks");

endmodule

### tb/alias_table_sampler_test.sv
`timescale 1ns / 1ps
// ============================================================================
// alias_table_sampler_test
// Self-checking bench for the alias-method sampler. A short directed part
// covers the status codes, the field extremes and the rebuild cases; random
// phases then reconfigure table_size, reload the table in shuffled order and
// draw samples while both stream sides idle at random. Every result is checked
// against a predictor that keeps its own copy of the weight and alias tables.
// ============================================================================
module alias_table_sampler_test;
    import ats_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 650;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int MAX_ERR_LINES = 100;

    // One request as it travels on the input stream.
    typedef struct {
        req_t                kind;
        logic [IDX_W-1:0]    entry;
        logic [PROB_W-1:0]   prob;
        logic                last;
        logic [IDX_W-1:0]    rand_idx;
        logic [FRAC_W-1:0]   rand_frac;
    } sampler_req_t;

    // One result as it travels on the output stream.
    typedef struct {
        logic [IDX_W-1:0] picked;
        status_t          status;
    } sampler_resp_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TSIZE_W-1:0]     cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // Predictor state: its own copy of the register and both tables.
    logic [TSIZE_W-1:0]  model_tsize = TSIZE_RESET;
    logic [WEIGHT_W-1:0] model_weight [MAX_ENTRIES];
    logic [IDX_W-1:0]    model_alias  [MAX_ENTRIES];
    bit                  model_built = 1'b0;

    // Stimulus bookkeeping, kept ahead of the bus as requests are queued.
    bit gen_written [MAX_ENTRIES];
    bit gen_built   = 1'b0;
    int gen_built_k = 0;
    int gen_k       = MAX_ENTRIES;
    int issued_reqs = 0;

    sampler_req_t  pending_reqs [$];
    sampler_resp_t expected_results [$];
    sampler_req_t  next_req;
    sampler_req_t  seen_req;
    sampler_resp_t want;

    int send_gap_max   = 0;
    int recv_stall_max = 0;
    int send_gap       = 0;
    int recv_stall     = 0;
    bit req_taken      = 1'b0;
    bit result_taken   = 1'b0;
    int error_count    = 0;
    int cycle_count    = 0;

    alias_table_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Number of outcomes in use for a given register value.
    function automatic int active_count(input logic [TSIZE_W-1:0] tsize);
        if (tsize == 0)
            return 1;
        if (tsize > MAX_ENTRIES)
            return MAX_ENTRIES;
        return int'(tsize);
    endfunction

    // Rebuild the alias table from the first k weights (Vose pairing).
    function automatic void build_alias_table();
        int                k;
        int                i;
        int                n_light;
        int                n_heavy;
        int                light [MAX_ENTRIES];
        int                heavy [MAX_ENTRIES];
        int                s;
        int                l;
        longint unsigned   kw;
        longint unsigned   scaled;
        longint unsigned   sum;
        k = active_count(model_tsize);
        kw = k;
        n_light = 0;
        n_heavy = 0;
        // Scale every weight by the outcome count and sort it against one.
        for (i = 0; i < k; i++)
        begin
            scaled = kw * model_weight[i];
            if (scaled > MAX_WEIGHT)
                scaled = MAX_WEIGHT;
            model_weight[i] = WEIGHT_W'(scaled);
            if (model_weight[i] < ONE_WEIGHT)
            begin
                light[n_light] = i;
                n_light++;
            end
            else
            begin
                heavy[n_heavy] = i;
                n_heavy++;
            end
        end
        // Pair light with heavy entries; the heavy one gives up what the light one lacks.
        while (n_light > 0 && n_heavy > 0)
        begin
            n_light--;
            n_heavy--;
            s = light[n_light];
            l = heavy[n_heavy];
            sum = longint'(model_weight[l]) + model_weight[s];
            model_alias[s] = IDX_W'(l);
            model_weight[l] = (sum > ONE_WEIGHT) ? WEIGHT_W'(sum - ONE_WEIGHT) : '0;
            if (model_weight[l] < ONE_WEIGHT)
            begin
                light[n_light] = l;
                n_light++;
            end
            else
            begin
                heavy[n_heavy] = l;
                n_heavy++;
            end
        end
        // Whatever is left on either side gets full weight and points at itself.
        while (n_light > 0)
        begin
            n_light--;
            model_weight[light[n_light]] = ONE_WEIGHT;
            model_alias[light[n_light]] = IDX_W'(light[n_light]);
        end
        while (n_heavy > 0)
        begin
            n_heavy--;
            model_weight[heavy[n_heavy]] = ONE_WEIGHT;
            model_alias[heavy[n_heavy]] = IDX_W'(heavy[n_heavy]);
        end
        model_built = 1'b1;
    endfunction

    // Expected result of one accepted request; loads also update the tables.
    function automatic sampler_resp_t predict_result(input sampler_req_t r);
        sampler_resp_t res;
        int            k;
        k = active_count(model_tsize);
        res.picked = '0;
        if (r.kind == REQ_LOAD)
        begin
            model_built = 1'b0;
            if (r.entry < k)
            begin
                model_weight[r.entry] = WEIGHT_W'(r.prob);
                res.status = STAT_LOAD_DONE;
            end
            else
                res.status = STAT_OUT_OF_RANGE;
            if (r.last)
                build_alias_table();
        end
        else if (!model_built)
            res.status = STAT_NOT_BUILT;
        else if (r.rand_idx >= k)
            res.status = STAT_OUT_OF_RANGE;
        else
        begin
            res.picked = (r.rand_frac < model_weight[r.rand_idx]) ?
                         r.rand_idx : model_alias[r.rand_idx];
            res.status = STAT_SAMPLE_OK;
        end
        return res;
    endfunction

    // True once every entry in use has held a weight since reset.
    function automatic bit table_loaded();
        int i;
        for (i = 0; i < gen_k; i++)
            if (!gen_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Queue a load; a build is only requested when it reads written entries alone.
    function automatic void queue_load(input int entry, input int prob, input bit last);
        sampler_req_t r;
        if (entry < gen_k)
            gen_written[entry] = 1'b1;
        r.kind      = REQ_LOAD;
        r.entry     = IDX_W'(entry);
        r.prob      = PROB_W'(prob);
        r.last      = last && table_loaded();
        r.rand_idx  = IDX_W'($urandom);
        r.rand_frac = FRAC_W'($urandom);
        gen_built   = r.last;
        if (r.last)
            gen_built_k = gen_k;
        pending_reqs.insert(pending_reqs.size(), r);
        issued_reqs++;
    endfunction

    // Queue a sample; after the size grew past the last build it stays in the built range.
    function automatic void queue_sample(input int ridx, input int rfrac);
        sampler_req_t r;
        if (gen_built && ridx < gen_k && ridx >= gen_built_k)
            ridx = ridx % gen_built_k;
        r.kind      = REQ_SAMPLE;
        r.entry     = IDX_W'($urandom);
        r.prob      = PROB_W'($urandom);
        r.last      = 1'($urandom_range(0, 1));
        r.rand_idx  = IDX_W'(ridx);
        r.rand_frac = FRAC_W'(rfrac);
        pending_reqs.insert(pending_reqs.size(), r);
        issued_reqs++;
    endfunction

    function automatic int draw_prob(input int k);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65536;
            2: return 131071;
            3, 4: return $urandom_range(0, 131071);
            5, 6: return $urandom_range(0, 65536);
            // Near a fair share of one.
            default: return $urandom_range(65536 / k / 2, 65536 * 3 / (2 * k));
        endcase
    endfunction

    function automatic int draw_frac();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Hold off until every queued request has been answered.
    task automatic wait_for_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_size(input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= TSIZE_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_tsize = TSIZE_W'(value);
        gen_k = active_count(TSIZE_W'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase: new size, shuffled reload with some noise, then samples.
    task automatic run_random_phase(input int tsize);
        int order [MAX_ENTRIES];
        int n_load;
        int n_samp;
        int i;
        int j;
        int t;
        bit oor_finish;
        wait_for_idle();
        write_table_size(tsize);
        send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 15;
        recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
        // A shrunk table stays usable without a rebuild.
        if (gen_built && gen_k <= gen_built_k && $urandom_range(0, 1))
            for (i = 0; i < 4; i++)
                queue_sample($urandom_range(0, gen_k - 1), draw_frac());
        for (i = 0; i < gen_k; i++)
            order[i] = i;
        for (i = gen_k - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        // With every entry already written, a partial reload reuses reduced weights.
        n_load = gen_k;
        if (table_loaded() && $urandom_range(0, 2) == 0)
            n_load = $urandom_range(1, (gen_k < 16) ? gen_k : 16);
        oor_finish = (gen_k < MAX_ENTRIES) && ($urandom_range(0, 5) == 0);
        for (i = 0; i < n_load; i++)
        begin
            case ($urandom_range(0, 19))
                0: if (gen_k < MAX_ENTRIES)
                       queue_load($urandom_range(gen_k, MAX_ENTRIES - 1), draw_prob(gen_k), 1'b0);
                1: queue_sample($urandom_range(0, 255), draw_frac());
                default: ;
            endcase
            queue_load(order[i], draw_prob(gen_k), (i == n_load - 1) && !oor_finish);
        end
        // The build can also be started by a load outside the table.
        if (oor_finish)
            queue_load($urandom_range(gen_k, MAX_ENTRIES - 1), draw_prob(gen_k), 1'b1);
        n_samp = $urandom_range(8, 30);
        for (i = 0; i < n_samp; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                queue_load($urandom_range(0, gen_k - 1), draw_prob(gen_k),
                           1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 6) == 0)
                queue_sample($urandom_range(0, 255), draw_frac());
            else
                queue_sample($urandom_range(0, gen_k - 1), draw_frac());
        end
    endtask

    task automatic report_mismatch(input string what);
        if (error_count < MAX_ERR_LINES)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Request driver: holds a request until taken, then waits its drawn gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    s_tdata  <= S_TDATA_W'({next_req.rand_frac, next_req.rand_idx,
                                            next_req.prob, next_req.entry});
                    s_tuser  <= next_req.kind;
                    s_tlast  <= next_req.last;
                    s_tvalid <= 1'b1;
                    send_gap = $urandom_range(0, send_gap_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls a drawn number of cycles after each result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
                recv_stall = $urandom_range(0, recv_stall_max);
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: predict on each taken request, check each taken result in order.
    always @(posedge clk)
    begin
        req_taken    = rst_n && s_tvalid && s_tready;
        result_taken = rst_n && m_tvalid && m_tready;
        if (req_taken)
        begin
            seen_req.kind      = req_t'(s_tuser);
            seen_req.entry     = s_tdata[0 +: IDX_W];
            seen_req.prob      = s_tdata[IDX_W +: PROB_W];
            seen_req.rand_idx  = s_tdata[IDX_W + PROB_W +: IDX_W];
            seen_req.rand_frac = s_tdata[2 * IDX_W + PROB_W +: FRAC_W];
            seen_req.last      = s_tlast;
            expected_results.push_back(predict_result(seen_req));
        end
        if (result_taken)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result index %0d status %0d with no request waiting",
                                          m_tdata, m_tuser));
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== want.picked)
                    report_mismatch($sformatf("picked_index %0d, expected %0d",
                                              m_tdata, want.picked));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              m_tuser, want.status.name()));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        int directed_count;
        int phase;
        int tsize;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_gap_max   = 3;
        recv_stall_max = 3;
        // Nothing built yet: samples report the missing table, loads still land.
        queue_sample(0, 0);
        queue_sample(255, 65535);
        queue_load(255, 65536, 1'b0);
        queue_sample(17, 12345);

        // One outcome, with the build started by a load outside the table.
        wait_for_idle();
        write_table_size(1);
        queue_load(0, 65536, 1'b0);
        queue_load(200, 0, 1'b1);
        queue_sample(0, 0);
        queue_sample(0, 65535);
        queue_sample(1, 0);
        queue_sample(255, 65535);

        // A size of zero also means one outcome; its weight is above one.
        wait_for_idle();
        write_table_size(0);
        queue_load(0, 131071, 1'b1);
        queue_sample(0, 65535);
        queue_sample(3, 0);

        // Four outcomes with empty, oversized, light and heavy weights.
        wait_for_idle();
        write_table_size(4);
        queue_load(0, 0, 1'b0);
        queue_load(1, 131071, 1'b0);
        queue_load(2, 16384, 1'b0);
        queue_load(3, 49152, 1'b1);
        queue_sample(0, 0);
        queue_sample(1, 65535);
        queue_sample(2, 32767);
        queue_sample(3, 65535);
        // A load without last drops the table; the rebuild reuses reduced weights.
        queue_load(2, 100, 1'b0);
        queue_sample(2, 0);
        queue_load(1, 65536, 1'b1);
        queue_sample(1, 0);
        queue_sample(3, 0);
        directed_count = issued_reqs;

        // Random phases: mostly small tables, one full table and oversized sizes.
        phase = 0;
        while (issued_reqs - directed_count < RANDOM_ITEMS)
        begin
            if (phase == 2)
                tsize = MAX_ENTRIES;
            else if (phase == 5)
                tsize = 511;
            else
            begin
                case ($urandom_range(0, 9))
                    0: tsize = $urandom_range(0, 1);
                    1: tsize = $urandom_range(17, 80);
                    2: tsize = (phase > 2) ? $urandom_range(257, 511) : $urandom_range(2, 16);
                    default: tsize = $urandom_range(2, 16);
                endcase
            end
            run_random_phase(tsize);
            phase++;
        end

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/ats_pkg.sv
rtl/ats_ram.sv
rtl/alias_table_sampler.sv
tb/alias_table_sampler_test.sv
